// File: sv/clkm_pkg.sv
package clkm_pkg;

  // special characters of the line protocol
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NUL   = 8'd0;

  // configuration register indexes
  localparam logic [2:0] CFG_ENTRY_COUNT = 3'd0;
  localparam logic [2:0] CFG_KW0_TEXT    = 3'd1;
  localparam logic [2:0] CFG_KW0_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_KW1_TEXT    = 3'd3;
  localparam logic [2:0] CFG_KW1_LENGTH  = 3'd4;
  localparam logic [2:0] CFG_KW2_TEXT    = 3'd5;
  localparam logic [2:0] CFG_KW2_LENGTH  = 3'd6;

  // register indexes per table entry, entry 0 in the lowest slot
  localparam logic [2:0][2:0] CFG_TEXT_IDX = {CFG_KW2_TEXT, CFG_KW1_TEXT, CFG_KW0_TEXT};
  localparam logic [2:0][2:0] CFG_LEN_IDX  =
    {CFG_KW2_LENGTH, CFG_KW1_LENGTH, CFG_KW0_LENGTH};

  // reset contents of the keyword table: "!showall", "!help", "!?"
  localparam logic [1:0] ENTRY_COUNT_RST = 2'd3;
  localparam logic [2:0][63:0] KW_TEXT_RST =
    {64'd16161, 64'd482854922273, 64'd7812726619179086625};
  localparam logic [2:0][3:0] KW_LEN_RST = {4'd2, 4'd5, 4'd8};

  // result item, matched in the lowest bit
  typedef struct packed {
    logic [6:0] line_length;
    logic [5:0] arg_length;
    logic [1:0] command_index;
    logic       matched;
  } res_t;

endpackage

// File: sv/command_line_keyword_matcher.sv
// Command line keyword matcher.
// The input stream carries one received character per request (in_tdata).
// Carriage returns are dropped, a line feed closes the line, and the line
// also closes when its counted bytes reach LINE_LIMIT. The head (bytes before
// the first space that is not preceded by a zero byte) is compared with up
// to three keywords held in the configuration registers; the lowest entry
// in use that matches exactly in length and bytes wins.
// One result request per closed line leaves on the output stream; lines
// that have not closed give nothing.
// Timing: a character is taken into an input register, then the line state
// and result register are updated from it when it drains, so out_tvalid
// rises once the closing character has moved on into the result register.
// One character is taken every cycle while no result is held by a stalled
// receiver; the per-character compare against all entries runs in parallel.
// When the receiver stalls with a result waiting, the result register holds
// and the character in the input register waits behind it, so in_tready
// drops once that register is full, whether or not the character closes a line.
// Reset clears the line state and loads the default keyword table.
// The configuration channel is always ready; write it only while idle.
module command_line_keyword_matcher #(
  parameter int LINE_LIMIT    = 64,
  parameter int KEYWORD_BYTES = 8,
  parameter int TABLE_ENTRIES = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] matched, [2:1] command_index,
                                  // [8:3] arg_length, [15:9] line_length
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CW = $clog2(LINE_LIMIT + 1);
  localparam int TW = 8 * KEYWORD_BYTES;
  localparam int WW = 9;

  // keyword table
  logic [1:0]                          entry_count_r;
  logic [TABLE_ENTRIES-1:0][TW-1:0]    kw_text_r;
  logic [TABLE_ENTRIES-1:0][3:0]       kw_len_r;

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // line state
  logic [CW-1:0]            char_count_r, char_count_nxt;
  logic [CW-1:0]            head_count_r, head_count_nxt;
  logic                     space_found_r, space_found_nxt;
  logic                     nul_seen_r, nul_seen_nxt;
  logic [TABLE_ENTRIES-1:0] still_match_r, still_match_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  clkm_pkg::res_t    out_res_r, out_res_nxt;

  logic                     advance, fire, is_cr, is_lf, take_head, line_close, hit;
  logic [CW-1:0]            count_inc;
  logic [TABLE_ENTRIES-1:0] byte_hit;
  logic [1:0]               hit_idx;
  logic [WW-1:0]            arg_w, head_w, count_w;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign fire       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  // configuration writes, out of range indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= clkm_pkg::ENTRY_COUNT_RST;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        kw_text_r[k] <= clkm_pkg::KW_TEXT_RST[k][TW-1:0];
        kw_len_r[k]  <= clkm_pkg::KW_LEN_RST[k];
      end
    end else if (cfg_valid) begin
      if (cfg_index == clkm_pkg::CFG_ENTRY_COUNT) begin
        entry_count_r <= cfg_data[1:0];
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (cfg_index == clkm_pkg::CFG_TEXT_IDX[k]) begin
          kw_text_r[k] <= cfg_data[TW-1:0];
        end
        if (cfg_index == clkm_pkg::CFG_LEN_IDX[k]) begin
          kw_len_r[k] <= cfg_data[3:0];
        end
      end
    end
  end

  // input register load and drain
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // per-entry compare of the current head byte
  always_comb begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      byte_hit[k] = 1'b0;
      for (int j = 0; j < KEYWORD_BYTES; j++) begin
        if (head_count_r == CW'(j) && {1'b0, 4'(j)} < {1'b0, kw_len_r[k]} &&
            kw_text_r[k][8*j +: 8] == in_byte_r) begin
          byte_hit[k] = 1'b1;
        end
      end
    end
  end

  // line state update and result build
  always_comb begin
    is_cr           = (in_byte_r == clkm_pkg::CH_CR);
    is_lf           = (in_byte_r == clkm_pkg::CH_LF);
    count_inc       = char_count_r + 1'b1;
    take_head       = !space_found_r && (nul_seen_r || in_byte_r != clkm_pkg::CH_SPACE);
    char_count_nxt  = char_count_r;
    head_count_nxt  = head_count_r;
    space_found_nxt = space_found_r;
    nul_seen_nxt    = nul_seen_r;
    still_match_nxt = still_match_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_res_nxt     = out_res_r;

    if (fire && !is_cr && !is_lf) begin
      char_count_nxt = count_inc;
      if (take_head) begin
        if (in_byte_r == clkm_pkg::CH_NUL) begin
          nul_seen_nxt = 1'b1;
        end
        still_match_nxt = still_match_r & byte_hit;
        head_count_nxt  = head_count_r + 1'b1;
      end else if (!space_found_r) begin
        space_found_nxt = 1'b1;
      end
    end

    line_close = fire && (is_lf || (!is_cr && count_inc >= CW'(LINE_LIMIT)));

    // lowest matching entry in use
    hit     = 1'b0;
    hit_idx = 2'd0;
    head_w  = {{(WW-CW){1'b0}}, head_count_nxt};
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (2'(k) < entry_count_r && still_match_nxt[k] &&
          head_w == {{(WW-4){1'b0}}, kw_len_r[k]}) begin
        hit     = 1'b1;
        hit_idx = 2'(k);
      end
    end

    count_w = {{(WW-CW){1'b0}}, char_count_nxt};
    arg_w   = space_found_nxt ? (count_w - head_w - 1'b1) : '0;

    if (line_close) begin
      out_valid_nxt             = 1'b1;
      out_res_nxt.matched       = hit;
      out_res_nxt.command_index = hit_idx;
      out_res_nxt.arg_length    = arg_w[5:0];
      out_res_nxt.line_length   = count_w[6:0];
      char_count_nxt            = '0;
      head_count_nxt            = '0;
      space_found_nxt           = 1'b0;
      nul_seen_nxt              = 1'b0;
      still_match_nxt           = '1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      char_count_r  <= '0;
      head_count_r  <= '0;
      space_found_r <= 1'b0;
      nul_seen_r    <= 1'b0;
      still_match_r <= '1;
    end else begin
      in_valid_r    <= in_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      char_count_r  <= char_count_nxt;
      head_count_r  <= head_count_nxt;
      space_found_r <= space_found_nxt;
      nul_seen_r    <= nul_seen_nxt;
      still_match_r <= still_match_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

endmodule
